// File: rtl/core/active_slot_tier_arbiter_defines.svh
// Assertion helpers for the tier arbiter.
`ifndef ACTIVE_SLOT_TIER_ARBITER_DEFINES_SVH
`define ACTIVE_SLOT_TIER_ARBITER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define ASTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASTA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/asta_pkg.sv
`default_nettype none

package asta_pkg;

  localparam int SLOTS = 16;
  localparam int STAMP_BITS = 32;
  localparam int IDX_BITS = $clog2(SLOTS);

  typedef enum logic [2:0] {
    TIER_ALARM  = 3'd0,
    TIER_PICK   = 3'd1,
    TIER_HOLDER = 3'd2,
    TIER_ACTIVE = 3'd3,
    TIER_PLAIN  = 3'd4
  } tier_e;

  typedef struct packed {
    logic [3:0] slot;
    logic       eligible;
    logic       shows_alarm;
    logic [1:0] alarm_priority;
    logic       operator_pick;
    logic       pass_end;
  } in_rec_t;

  typedef struct packed {
    logic       winner_valid;
    logic [3:0] winner_slot;
    logic       winner_alarm;
    logic       active_changed;
  } out_rec_t;

  // one record as it is processed: go = processed this cycle,
  // live = eligible and slot inside the store
  typedef struct packed {
    logic    go;
    logic    live;
    in_rec_t data;
  } rec_t;

endpackage

`default_nettype wire

// File: rtl/core/asta_stamp_store.sv
`default_nettype none

module asta_stamp_store (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire asta_pkg::rec_t               rec_i,
  output logic [asta_pkg::STAMP_BITS-1:0]   stamp_o
);
  import asta_pkg::*;

  logic [STAMP_BITS-1:0] store_q [SLOTS];
  logic [STAMP_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [STAMP_BITS-1:0] cur, wr_val;
  logic [IDX_BITS-1:0]   idx;
  logic                  wr_en;

  assign idx     = IDX_BITS'(rec_i.data.slot);
  assign cur     = store_q[idx];
  assign cnt_inc = cnt_q + STAMP_BITS'(1);

  always_comb begin
    cnt_d  = cnt_q;
    wr_en  = 1'b0;
    wr_val = '0;
    stamp_o = '0;
    if (rec_i.go && rec_i.live) begin
      if (rec_i.data.shows_alarm) begin
        if (cur == '0) begin
          cnt_d  = (cnt_inc == '0) ? STAMP_BITS'(1) : cnt_inc;
          wr_en  = 1'b1;
          wr_val = cnt_d;
          stamp_o = cnt_d;
        end else begin
          stamp_o = cur;
        end
      end else begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        store_q[idx] <= wr_val;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/asta_score.sv
`default_nettype none

module asta_score (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire asta_pkg::rec_t               rec_i,
  input  wire logic [asta_pkg::STAMP_BITS-1:0] stamp_i,
  output logic                              res_fire_o,
  output asta_pkg::out_rec_t                res_o
);
  import asta_pkg::*;

  logic                  found_q, found_d;
  logic [3:0]            idx_q, idx_d;
  tier_e                 tier_q, tier_d;
  logic [1:0]            prio_q, prio_d;
  logic [STAMP_BITS-1:0] bstamp_q, bstamp_d;
  logic                  act_valid_q, act_valid_d;
  logic [3:0]            act_idx_q, act_idx_d;
  logic                  hold_valid_q, hold_valid_d;
  logic [3:0]            hold_idx_q, hold_idx_d;

  tier_e      tier_c;
  logic [1:0] prio_c;
  logic       outranks, take;
  logic       e_found;
  logic [3:0] e_idx;
  tier_e      e_tier;
  logic [1:0] e_prio;
  logic [STAMP_BITS-1:0] e_stamp;
  logic [3:0] widx;
  logic       walarm;

  always_comb begin
    prio_c = '0;
    if (rec_i.data.shows_alarm) begin
      tier_c = TIER_ALARM;
      prio_c = rec_i.data.alarm_priority;
    end else if (rec_i.data.operator_pick) begin
      tier_c = TIER_PICK;
    end else if (hold_valid_q && rec_i.data.slot == hold_idx_q) begin
      tier_c = TIER_HOLDER;
    end else if (act_valid_q && rec_i.data.slot == act_idx_q) begin
      tier_c = TIER_ACTIVE;
    end else begin
      tier_c = TIER_PLAIN;
    end

    if (tier_c != tier_q) begin
      outranks = tier_c < tier_q;
    end else if (tier_c != TIER_ALARM) begin
      outranks = 1'b0;
    end else if (prio_c != prio_q) begin
      outranks = prio_c < prio_q;
    end else begin
      outranks = stamp_i < bstamp_q;
    end

    take = rec_i.go && rec_i.live && (!found_q || outranks);

    e_found = found_q | take;
    e_idx   = take ? rec_i.data.slot : idx_q;
    e_tier  = tier_q;
    if (take) begin
      e_tier = tier_c;
    end
    e_prio  = take ? prio_c : prio_q;
    e_stamp = take ? stamp_i : bstamp_q;

    widx   = e_found ? e_idx : 4'd0;
    walarm = e_found && (e_tier == TIER_ALARM);

    res_fire_o = rec_i.go && rec_i.data.pass_end;
    res_o.winner_valid   = e_found;
    res_o.winner_slot    = widx;
    res_o.winner_alarm   = walarm;
    res_o.active_changed = e_found ? (!act_valid_q || act_idx_q != widx) : act_valid_q;

    found_d  = e_found;
    idx_d    = e_idx;
    tier_d   = e_tier;
    prio_d   = e_prio;
    bstamp_d = e_stamp;
    act_valid_d  = act_valid_q;
    act_idx_d    = act_idx_q;
    hold_valid_d = hold_valid_q;
    hold_idx_d   = hold_idx_q;
    if (res_fire_o) begin
      act_valid_d = e_found;
      act_idx_d   = widx;
      if (e_found && !walarm) begin
        hold_valid_d = 1'b1;
        hold_idx_d   = widx;
      end
      found_d  = 1'b0;
      idx_d    = '0;
      tier_d   = TIER_PLAIN;
      prio_d   = '0;
      bstamp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      idx_q        <= '0;
      tier_q       <= TIER_PLAIN;
      prio_q       <= '0;
      bstamp_q     <= '0;
      act_valid_q  <= 1'b0;
      act_idx_q    <= '0;
      hold_valid_q <= 1'b0;
      hold_idx_q   <= '0;
    end else begin
      found_q      <= found_d;
      idx_q        <= idx_d;
      tier_q       <= tier_d;
      prio_q       <= prio_d;
      bstamp_q     <= bstamp_d;
      act_valid_q  <= act_valid_d;
      act_idx_q    <= act_idx_d;
      hold_valid_q <= hold_valid_d;
      hold_idx_q   <= hold_idx_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/active_slot_tier_arbiter.sv
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid_i/in_stall_o  | in_data_i  (asta_pkg::in_rec_t)
// out     | out | out_valid_o/out_stall_i| out_data_o (asta_pkg::out_rec_t)
//
// One record per cycle unless the input stalls; the output takes one result
// per pass. A record sits in the input register while the stamp lookup, tier
// compare and state update run; its pass result goes into the output register
// when the pass_end record is processed, which raises out_valid_o.
// Only a pass_end record facing a stalled full output register stalls the input.
// Reset clears stamps, the counter, active and holder state at once.
`default_nettype none

`include "active_slot_tier_arbiter_defines.svh"

module active_slot_tier_arbiter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire asta_pkg::in_rec_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output asta_pkg::out_rec_t      out_data_o
);
  import asta_pkg::*;

  logic     in_valid_q, in_valid_d;
  in_rec_t  in_q;
  logic     out_valid_q, out_valid_d;
  out_rec_t out_q;
  logic     in_fire, proc_go, out_blocked;
  rec_t     rec;
  logic [STAMP_BITS-1:0] stamp;
  logic     res_fire;
  out_rec_t res;

  assign out_blocked = out_valid_q && out_stall_i;
  assign proc_go     = in_valid_q && !(in_q.pass_end && out_blocked);
  assign in_stall_o  = in_valid_q && !proc_go;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_fire || (in_valid_q && !proc_go);
  assign out_valid_d = res_fire || out_blocked;

  assign rec.go   = proc_go;
  assign rec.live = in_q.eligible && (32'(in_q.slot) < 32'(SLOTS));
  assign rec.data = in_q;

  asta_stamp_store u_stamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (rec),
    .stamp_o (stamp)
  );

  asta_score u_score (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_i      (rec),
    .stamp_i    (stamp),
    .res_fire_o (res_fire),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    if (res_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASTA_ASSERT_IMP(a_no_overwrite, res_fire, !out_blocked, "result overwrote a held result")
  `ASTA_ASSERT_IMP(a_stall_only_full, in_stall_o, in_q.pass_end && out_blocked, "stall without cause")
  `ASTA_ASSERT_IMP(a_none_zero, out_valid_q && !out_q.winner_valid,
                   out_q.winner_slot == 4'd0 && !out_q.winner_alarm, "empty winner not zero")
  `ASTA_ASSERT_NXT(a_pass_result, proc_go && in_q.pass_end, out_valid_q, "pass end lost result")

endmodule

`default_nettype wire
